// ----- design/sliding_window_hit_counter_macros.svh -----
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef SLIDING_WINDOW_HIT_COUNTER_MACROS_SVH
`define SLIDING_WINDOW_HIT_COUNTER_MACROS_SVH

`ifndef ASSERT_OFF
`define SWHC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWHC_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SWHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWHC_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- design/swhc_pkg.sv -----
package swhc_pkg;

    localparam int WINDOW_DEF = 300;
    localparam int TIME_W     = 31;
    localparam int COUNT_W    = 32;
    localparam int ENTRY_W    = TIME_W + COUNT_W;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_count COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic OP_HIT   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

// ----- design/swhc_bucket_ram.sv -----
module swhc_bucket_ram
    import swhc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    localparam int AW = $clog2(WINDOW)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    // Each entry is {stored time, hit count}.
    logic [ENTRY_W-1:0] r_mem [WINDOW];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/swhc_slot_div.sv -----
module swhc_slot_div
    import swhc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    localparam int AW = $clog2(WINDOW)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_time         i_dividend,
    output logic          o_done,
    output logic [AW-1:0] o_rem
);

    // The quotient comes from a multiply by the rounded-up reciprocal of
    // WINDOW with TIME_W + AW fraction bits, which is exact for every
    // timestamp. Three pipelined steps follow the load: product, quotient
    // times WINDOW, and the remainder.
    localparam int SH = TIME_W + AW;
    localparam int MW = TIME_W + 1;
    localparam int PW = TIME_W + MW;
    localparam int QW = PW - SH;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
    localparam t_time WIN_T = TIME_W'(WINDOW);

    logic          r_v1;
    logic          r_v2;
    logic          r_v3;
    logic          r_done;
    t_time         r_dvd;
    logic [PW-1:0] r_prod;
    t_time         r_qw;
    logic [AW-1:0] r_rem;
    logic [QW-1:0] quo;

    assign quo = r_prod[PW-1:SH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3;
        end
        if (i_start) begin
            r_dvd <= i_dividend;
        end
        r_prod <= PW'(r_dvd) * PW'(RECIP);
        r_qw   <= t_time'(quo) * WIN_T;
        r_rem  <= AW'(r_dvd - r_qw);
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- design/sliding_window_hit_counter.sv -----
// Sliding window hit counter with one bucket per second modulo WINDOW.
// Input beats arrive on s_axis: tuser is the opcode (hit or query) and
// tdata carries the timestamp in seconds. A hit beat produces no output;
// a query beat produces one beat on m_axis holding the saturating number
// of hits stamped less than WINDOW seconds before the query time or after it.
// The block takes one beat at a time; s_axis_tready is high only while it
// is idle. A hit finds its slot with a multiply by the reciprocal of
// WINDOW (three pipelined steps), then reads the bucket and writes it
// back before the next beat can be taken. A query reads every bucket
// through the single memory read port, one per cycle, then passes
// through S_QDRAIN and S_QOUT, where the result goes to the output
// register, before the next beat can be taken.
// After reset the bucket memory is cleared by a pass over all WINDOW
// entries, one entry per cycle, during which no beat is accepted.
// The result sits in an output register; the next beat is accepted while
// it waits, but a later query holds its result until m_axis_tready has
// taken the previous one.
`include "sliding_window_hit_counter_macros.svh"

module sliding_window_hit_counter
    import swhc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] timestamp, [31] zero fill
    input  logic        s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] hit_total
);

    localparam int AW = $clog2(WINDOW);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_HUPD   = 3'd3;
    localparam logic [2:0] S_QSCAN  = 3'd4;
    localparam logic [2:0] S_QDRAIN = 3'd5;
    localparam logic [2:0] S_QOUT   = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    t_time              r_ts, n_ts;
    logic               r_pend, n_pend;
    t_count             r_sum, n_sum;
    logic               r_out_valid, n_out_valid;
    t_count             r_out_data, n_out_data;

    logic               in_acc;
    logic               div_start;
    logic               div_done;
    logic [AW-1:0]      div_rem;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_time              rd_time;
    t_count             rd_count;
    logic [31:0]        age;
    logic               in_window;
    logic [COUNT_W:0]   sum_ext;
    t_count             hit_count;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign div_start     = in_acc & (s_axis_tuser == OP_HIT);

    assign rd_time  = ram_rdata[ENTRY_W-1:COUNT_W];
    assign rd_count = ram_rdata[COUNT_W-1:0];

    // Age is signed so that a bucket stamped later than the query counts.
    assign age       = {1'b0, r_ts} - {1'b0, rd_time};
    assign in_window = $signed(age) < $signed(32'(WINDOW));
    assign sum_ext   = {1'b0, r_sum} + {1'b0, rd_count};

    always_comb begin
        if (rd_time != r_ts) begin
            hit_count = t_count'(1);
        end else if (rd_count == COUNT_MAX) begin
            hit_count = COUNT_MAX;
        end else begin
            hit_count = rd_count + 1'b1;
        end
    end

    swhc_slot_div #(
        .WINDOW(WINDOW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (s_axis_tdata[TIME_W-1:0]),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    swhc_bucket_ram #(
        .WINDOW(WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_ts        = r_ts;
        n_pend      = (r_state == S_QSCAN);
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = {r_ts, hit_count};
        ram_raddr   = r_idx;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // Bucket data read in the previous scan cycle is folded in here.
        if (r_pend && in_window) begin
            n_sum = sum_ext[COUNT_W] ? COUNT_MAX : sum_ext[COUNT_W-1:0];
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_idx == AW'(WINDOW - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_ts = s_axis_tdata[TIME_W-1:0];
                    if (s_axis_tuser == OP_HIT) begin
                        n_state = S_DIV;
                    end else begin
                        n_idx   = '0;
                        n_sum   = '0;
                        n_state = S_QSCAN;
                    end
                end
            end
            S_DIV: begin
                ram_raddr = div_rem;
                if (div_done) begin
                    n_idx   = div_rem;
                    n_state = S_HUPD;
                end
            end
            S_HUPD: begin
                ram_we  = 1'b1;
                n_idx   = '0;
                n_state = S_IDLE;
            end
            S_QSCAN: begin
                if (r_idx == AW'(WINDOW - 1)) begin
                    n_state = S_QDRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_QDRAIN: begin
                n_state = S_QOUT;
            end
            S_QOUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_sum;
                    n_idx       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_idx   = '0;
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_ts       <= n_ts;
        r_sum      <= n_sum;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `SWHC_ASSERT(a_hit_to_div, i_clk, i_rst_n,
        in_acc && (s_axis_tuser == OP_HIT) |=> r_state == S_DIV,
        "hit beat did not start the slot remainder")
    `SWHC_ASSERT(a_done_in_div, i_clk, i_rst_n,
        div_done |-> r_state == S_DIV,
        "remainder finished outside the hit sequence")
    `SWHC_ASSERT(a_pend_in_scan, i_clk, i_rst_n,
        r_pend |-> (r_state == S_QDRAIN || r_state == S_QSCAN),
        "bucket data pending outside a query scan")
    `SWHC_ASSERT(a_out_from_query, i_clk, i_rst_n,
        $rose(m_axis_tvalid) |-> $past(r_state) == S_QOUT,
        "output beat raised without a finished query")
    `SWHC_NEVER(a_idx_range, i_clk, i_rst_n,
        r_idx > AW'(WINDOW - 1),
        "bucket index beyond the window")

endmodule
